/* sv/ces_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_pkg
// Shared types and constants of the class evidence score table.
// ----------------------------------------------------------------------------
package ces_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int NUM_CLASSES_DEF   = 12;
	localparam int SCORE_W           = 16;
	localparam int ID_W              = 32;
	localparam int CLASS_W           = 4;
	localparam int SLOT_OUT_W        = 4;
	localparam int COUNT_OUT_W       = 5;
	localparam int CFG_IDX_W         = 3;

	typedef enum logic [2:0] {
		MODE_TRACK_BEGIN  = 3'd0,
		MODE_TRACK_ID     = 3'd1,
		MODE_TRACK_END    = 3'd2,
		MODE_DETECT_BEGIN = 3'd3,
		MODE_DETECT       = 3'd4,
		MODE_DETECT_END   = 3'd5,
		MODE_FEEDBACK     = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2,
		STS_UNKNOWN   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_SCORE_MAX      = 3'd0,
		CFG_DETECT_GAIN    = 3'd1,
		CFG_DETECT_PENALTY = 3'd2,
		CFG_MISS_DECAY     = 3'd3,
		CFG_MISS_FLOOR     = 3'd4,
		CFG_CONFIRM_GAIN   = 3'd5,
		CFG_REJECT_PENALTY = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ZERO,
		OP_DETECT,
		OP_DECAY,
		OP_CONFIRM,
		OP_REJECT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_RESOLVE,
		ST_DROP,
		ST_EOF_CHK,
		ST_EOF_NEXT,
		ST_CNT_RD,
		ST_CNT_DAT,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    clr_track;
		logic    clr_detect;
		logic    slot_clr;
		logic    slot_inc;
		logic    slot_found;
		logic    slot_free;
		logic    scan;
		logic    alloc;
		logic    mark_track;
		logic    mark_detect;
		logic    drop;
		logic    cls_clr;
		logic    cls_inc;
		logic    pos_clr;
		logic    cnt_pos;
		logic    mem_rd;
		logic    upd_wr;
		logic    set_op;
		op_t     op;
		logic    set_rep;
		status_t status;
		logic    has_entry;
	} ctrl_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  known;
		logic  verdict;
		logic  found;
		logic  free_ok;
		logic  slot_last;
		logic  cls_last;
		logic  slot_live;
	} dp_stat_t;

endpackage
`default_nettype wire

/* sv/ces_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_datapath
// Entry table, score memory, configuration registers and score arithmetic.
// ----------------------------------------------------------------------------
module ces_datapath #(
	parameter int TABLE_ENTRIES = ces_pkg::TABLE_ENTRIES_DEF,
	parameter int NUM_CLASSES   = ces_pkg::NUM_CLASSES_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire ces_pkg::ctrl_cmd_t               cmd,
	output ces_pkg::dp_stat_t                     stat,
	input  wire [2:0]                             mode,
	input  wire [ces_pkg::ID_W-1:0]               target_id,
	input  wire [ces_pkg::CLASS_W-1:0]            class_index,
	input  wire                                   verdict,
	input  wire                                   cfg_we,
	input  wire [ces_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [ces_pkg::SCORE_W-1:0]            cfg_data,
	output logic [1:0]                            status,
	output logic [ces_pkg::SLOT_OUT_W-1:0]        slot,
	output logic [ces_pkg::CLASS_W-1:0]           top_class,
	output logic [ces_pkg::SCORE_W-1:0]           top_score,
	output logic [ces_pkg::COUNT_OUT_W-1:0]       entry_count
);

	localparam int SW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNTW  = $clog2(TABLE_ENTRIES + 1);
	localparam int DEPTH = TABLE_ENTRIES * NUM_CLASSES;
	localparam int AW    = $clog2(DEPTH);
	localparam int W     = ces_pkg::SCORE_W;

	logic [W-1:0] score_max_q, detect_gain_q, detect_penalty_q, miss_decay_q;
	logic [W-1:0] miss_floor_q, confirm_gain_q, reject_penalty_q;

	ces_pkg::mode_t                 mode_q;
	logic [ces_pkg::ID_W-1:0]       tid_q;
	logic [ces_pkg::CLASS_W-1:0]    cls_in_q;
	logic                           right_q;

	logic [TABLE_ENTRIES-1:0]       valid_q, seen_track_q, seen_detect_q;
	logic [ces_pkg::ID_W-1:0]       id_q [TABLE_ENTRIES];
	logic [CNTW-1:0]                count_q;

	logic [SW-1:0]                  slot_q, found_slot_q, free_slot_q;
	logic                           found_q, free_q;
	logic [CW-1:0]                  cls_q;
	logic [1:0]                     pos_q;

	logic [W-1:0]                   mem [DEPTH];
	logic [W-1:0]                   rdata_q;
	logic [AW-1:0]                  addr;

	ces_pkg::op_t                   op_q;
	ces_pkg::status_t               status_q;
	logic                           has_entry_q;
	logic [CW-1:0]                  top_q;
	logic [W-1:0]                   best_q;

	logic [W-1:0]                   new_v, floor_v, dec_a, dec_b, decay_v;
	logic [W:0]                     sum_det, sum_cnf;
	logic [W-1:0]                   add_det, add_cnf, sub_pen, sub_rej;
	logic                           cls_hit;

	assign addr = AW'(slot_q) * AW'(NUM_CLASSES) + AW'(cls_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_max_q      <= W'(10000);
			detect_gain_q    <= W'(40);
			detect_penalty_q <= W'(10);
			miss_decay_q     <= W'(1);
			miss_floor_q     <= W'(100);
			confirm_gain_q   <= W'(1000);
			reject_penalty_q <= W'(500);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ces_pkg::CFG_SCORE_MAX:      score_max_q      <= cfg_data;
				ces_pkg::CFG_DETECT_GAIN:    detect_gain_q    <= cfg_data;
				ces_pkg::CFG_DETECT_PENALTY: detect_penalty_q <= cfg_data;
				ces_pkg::CFG_MISS_DECAY:     miss_decay_q     <= cfg_data;
				ces_pkg::CFG_MISS_FLOOR:     miss_floor_q     <= cfg_data;
				ces_pkg::CFG_CONFIRM_GAIN:   confirm_gain_q   <= cfg_data;
				ces_pkg::CFG_REJECT_PENALTY: reject_penalty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= ces_pkg::mode_t'(mode);
			tid_q    <= target_id;
			cls_in_q <= class_index;
			right_q  <= verdict;
		end
	end

	// entry table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			seen_track_q  <= '0;
			seen_detect_q <= '0;
			count_q       <= '0;
			found_q       <= 1'b0;
			free_q        <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end
			if (cmd.clr_track)
				seen_track_q <= '0;
			if (cmd.clr_detect)
				seen_detect_q <= '0;
			if (cmd.scan) begin
				if (valid_q[slot_q] && id_q[slot_q] == tid_q && !found_q)
					found_q <= 1'b1;
				if (!valid_q[slot_q] && !free_q)
					free_q <= 1'b1;
			end
			if (cmd.alloc) begin
				valid_q[free_slot_q]       <= 1'b1;
				seen_track_q[free_slot_q]  <= 1'b1;
				seen_detect_q[free_slot_q] <= 1'b0;
				count_q                    <= count_q + CNTW'(1);
			end
			if (cmd.mark_track)
				seen_track_q[found_slot_q] <= 1'b1;
			if (cmd.mark_detect)
				seen_detect_q[found_slot_q] <= 1'b1;
			// drop entries not listed in this track frame
			if (cmd.drop && valid_q[slot_q] && !seen_track_q[slot_q]) begin
				valid_q[slot_q] <= 1'b0;
				count_q         <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (valid_q[slot_q] && id_q[slot_q] == tid_q && !found_q)
				found_slot_q <= slot_q;
			if (!valid_q[slot_q] && !free_q)
				free_slot_q <= slot_q;
		end
		if (cmd.alloc)
			id_q[free_slot_q] <= tid_q;
	end

	// slot and class counters
	always_ff @(posedge clk) begin
		if (cmd.slot_clr)
			slot_q <= '0;
		else if (cmd.slot_inc)
			slot_q <= slot_q + SW'(1);
		else if (cmd.slot_found)
			slot_q <= found_slot_q;
		else if (cmd.slot_free)
			slot_q <= free_slot_q;
		if (cmd.cls_clr)
			cls_q <= '0;
		else if (cmd.cls_inc)
			cls_q <= cls_q + CW'(1);
		if (cmd.pos_clr)
			pos_q <= '0;
		else if (cmd.cnt_pos && rdata_q != '0 && pos_q != 2'd2)
			pos_q <= pos_q + 2'd1;
		if (cmd.set_op)
			op_q <= cmd.op;
		if (cmd.set_rep) begin
			status_q    <= cmd.status;
			has_entry_q <= cmd.has_entry;
		end
	end

	// score memory
	always_ff @(posedge clk) begin
		if (cmd.mem_rd)
			rdata_q <= mem[addr];
		if (cmd.upd_wr)
			mem[addr] <= new_v;
	end

	// score update
	always_comb begin
		cls_hit = (ces_pkg::CLASS_W'(cls_q) == cls_in_q);
		sum_det = {1'b0, rdata_q} + {1'b0, detect_gain_q};
		sum_cnf = {1'b0, rdata_q} + {1'b0, confirm_gain_q};
		add_det = (sum_det < {1'b0, score_max_q}) ? sum_det[W-1:0] : score_max_q;
		add_cnf = (sum_cnf < {1'b0, score_max_q}) ? sum_cnf[W-1:0] : score_max_q;
		sub_pen = (rdata_q > detect_penalty_q) ? rdata_q - detect_penalty_q : '0;
		sub_rej = (rdata_q > reject_penalty_q) ? rdata_q - reject_penalty_q : '0;
		floor_v = (pos_q == 2'd2) ? '0 : miss_floor_q;
		dec_a   = (rdata_q < floor_v) ? rdata_q : floor_v;
		dec_b   = (rdata_q > miss_decay_q) ? rdata_q - miss_decay_q : '0;
		decay_v = (dec_a > dec_b) ? dec_a : dec_b;
		case (op_q)
			ces_pkg::OP_ZERO:    new_v = '0;
			ces_pkg::OP_DETECT:  new_v = cls_hit ? add_det : sub_pen;
			ces_pkg::OP_DECAY:   new_v = decay_v;
			ces_pkg::OP_CONFIRM: new_v = cls_hit ? add_cnf : rdata_q;
			ces_pkg::OP_REJECT:  new_v = cls_hit ? sub_rej : rdata_q;
			default:             new_v = rdata_q;
		endcase
	end

	// top class: lowest index wins ties
	always_ff @(posedge clk) begin
		if (cmd.upd_wr && (cls_q == '0 || new_v > best_q)) begin
			best_q <= new_v;
			top_q  <= cls_q;
		end
	end

	always_comb begin
		stat.mode      = mode_q;
		stat.known     = ({1'b0, cls_in_q} < (ces_pkg::CLASS_W + 1)'(NUM_CLASSES));
		stat.verdict   = right_q;
		stat.found     = found_q;
		stat.free_ok   = free_q;
		stat.slot_last = (slot_q == SW'(TABLE_ENTRIES - 1));
		stat.cls_last  = (cls_q == CW'(NUM_CLASSES - 1));
		stat.slot_live = valid_q[slot_q] && !seen_detect_q[slot_q];
	end

	assign status      = status_q;
	assign slot        = has_entry_q ? ces_pkg::SLOT_OUT_W'(slot_q) : '0;
	assign top_class   = has_entry_q ? ces_pkg::CLASS_W'(top_q) : '0;
	assign top_score   = has_entry_q ? best_q : '0;
	assign entry_count = ces_pkg::COUNT_OUT_W'(count_q);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(TABLE_ENTRIES))
		else $error("entry count above table size");
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> free_q && !valid_q[free_slot_q])
		else $error("allocation into an occupied slot");
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |=> count_q == $past(count_q) + CNTW'(1))
		else $error("entry count missed an allocation");

endmodule
`default_nettype wire

/* sv/ces_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_ctrl
// Sequencer: slot scan, table sweeps and per-class score passes.
// ----------------------------------------------------------------------------
module ces_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	output logic                    done,
	input  wire ces_pkg::dp_stat_t  stat,
	output ces_pkg::ctrl_cmd_t      cmd
);

	ces_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ces_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ces_pkg::ST_IDLE);
		done    = 1'b0;
		unique case (state_q)
			ces_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ces_pkg::ST_DECODE;
				end
			end
			ces_pkg::ST_DECODE: begin
				cmd.set_rep   = 1'b1;
				cmd.status    = ces_pkg::STS_OK;
				cmd.has_entry = 1'b0;
				cmd.slot_clr  = 1'b1;
				unique case (stat.mode)
					ces_pkg::MODE_TRACK_BEGIN: begin
						cmd.clr_track = 1'b1;
						state_d       = ces_pkg::ST_DONE;
					end
					ces_pkg::MODE_DETECT_BEGIN: begin
						cmd.clr_detect = 1'b1;
						state_d        = ces_pkg::ST_DONE;
					end
					ces_pkg::MODE_TRACK_ID, ces_pkg::MODE_DETECT,
					ces_pkg::MODE_FEEDBACK:    state_d = ces_pkg::ST_SCAN;
					ces_pkg::MODE_TRACK_END:   state_d = ces_pkg::ST_DROP;
					ces_pkg::MODE_DETECT_END:  state_d = ces_pkg::ST_EOF_CHK;
					default:                   state_d = ces_pkg::ST_DONE;
				endcase
			end
			ces_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.slot_last)
					state_d = ces_pkg::ST_RESOLVE;
				else
					cmd.slot_inc = 1'b1;
			end
			ces_pkg::ST_RESOLVE: begin
				cmd.cls_clr = 1'b1;
				cmd.pos_clr = 1'b1;
				cmd.set_op  = 1'b1;
				cmd.set_rep = 1'b1;
				cmd.op      = ces_pkg::OP_NONE;
				cmd.status  = ces_pkg::STS_OK;
				state_d     = ces_pkg::ST_DONE;
				if (stat.mode == ces_pkg::MODE_TRACK_ID) begin
					if (stat.found) begin
						cmd.slot_found = 1'b1;
						cmd.mark_track = 1'b1;
						cmd.has_entry  = 1'b1;
						state_d        = ces_pkg::ST_UPD_RD;
					end else if (stat.free_ok) begin
						cmd.alloc     = 1'b1;
						cmd.slot_free = 1'b1;
						cmd.op        = ces_pkg::OP_ZERO;
						cmd.has_entry = 1'b1;
						state_d       = ces_pkg::ST_UPD_RD;
					end else begin
						cmd.status = ces_pkg::STS_FULL;
					end
				end else if (!stat.found) begin
					cmd.status = ces_pkg::STS_NOT_FOUND;
				end else begin
					cmd.slot_found = 1'b1;
					cmd.has_entry  = 1'b1;
					state_d        = ces_pkg::ST_UPD_RD;
					if (stat.mode == ces_pkg::MODE_DETECT) begin
						cmd.mark_detect = 1'b1;
						if (stat.known) begin
							cmd.op = ces_pkg::OP_DETECT;
						end else begin
							cmd.op     = ces_pkg::OP_DECAY;
							cmd.status = ces_pkg::STS_UNKNOWN;
							state_d    = ces_pkg::ST_CNT_RD;
						end
					end else if (stat.known) begin
						cmd.op = stat.verdict ? ces_pkg::OP_CONFIRM : ces_pkg::OP_REJECT;
					end else begin
						cmd.status = ces_pkg::STS_UNKNOWN;
					end
				end
			end
			ces_pkg::ST_DROP: begin
				cmd.drop = 1'b1;
				if (stat.slot_last)
					state_d = ces_pkg::ST_DONE;
				else
					cmd.slot_inc = 1'b1;
			end
			ces_pkg::ST_EOF_CHK: begin
				if (stat.slot_live) begin
					cmd.cls_clr = 1'b1;
					cmd.pos_clr = 1'b1;
					cmd.set_op  = 1'b1;
					cmd.op      = ces_pkg::OP_DECAY;
					state_d     = ces_pkg::ST_CNT_RD;
				end else begin
					state_d = ces_pkg::ST_EOF_NEXT;
				end
			end
			ces_pkg::ST_EOF_NEXT: begin
				if (stat.slot_last) begin
					state_d = ces_pkg::ST_DONE;
				end else begin
					cmd.slot_inc = 1'b1;
					state_d      = ces_pkg::ST_EOF_CHK;
				end
			end
			ces_pkg::ST_CNT_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ces_pkg::ST_CNT_DAT;
			end
			ces_pkg::ST_CNT_DAT: begin
				cmd.cnt_pos = 1'b1;
				if (stat.cls_last) begin
					cmd.cls_clr = 1'b1;
					state_d     = ces_pkg::ST_UPD_RD;
				end else begin
					cmd.cls_inc = 1'b1;
					state_d     = ces_pkg::ST_CNT_RD;
				end
			end
			ces_pkg::ST_UPD_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ces_pkg::ST_UPD_WR;
			end
			ces_pkg::ST_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				if (!stat.cls_last) begin
					cmd.cls_inc = 1'b1;
					state_d     = ces_pkg::ST_UPD_RD;
				end else if (stat.mode == ces_pkg::MODE_DETECT_END) begin
					state_d = ces_pkg::ST_EOF_NEXT;
				end else begin
					state_d = ces_pkg::ST_DONE;
				end
			end
			ces_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = ces_pkg::ST_IDLE;
			end
			default: state_d = ces_pkg::ST_IDLE;
		endcase
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_wr |-> $past(cmd.mem_rd))
		else $error("score write without a preceding read");

endmodule
`default_nettype wire

/* sv/class_evidence_score_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// class_evidence_score_table
// Tracked-id table with saturating per-class evidence scores.
//
// channel   handshake          payload
// input     start / busy       mode, target_id, class_index, verdict
// result    done (1 cycle)     status, slot, top_class, top_score, entry_count
// config    cfg_we             cfg_index, cfg_data
//
// Frame begin and unused modes go straight to the result; track end sweeps
// every slot. Track id, detect and feedback scan all slots, then read and
// write each class score, after a positive-score count pass for an unknown
// detection; an absent id or a full table ends after the scan.
// Detect end runs the count and decay passes on each slot unseen this frame.
// The id scan looks at one slot a cycle, and the single-port score
// memory is read, then written, for each class in turn. Reset clears all
// valid and seen bits at once; the score memory needs no clearing pass.
// The result strobe cannot be held off; busy stays high through it.
// ----------------------------------------------------------------------------
module class_evidence_score_table #(
	parameter int TABLE_ENTRIES = ces_pkg::TABLE_ENTRIES_DEF,
	parameter int NUM_CLASSES   = ces_pkg::NUM_CLASSES_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire [2:0]                       mode,
	input  wire [ces_pkg::ID_W-1:0]         target_id,
	input  wire [ces_pkg::CLASS_W-1:0]      class_index,
	input  wire                             verdict,
	input  wire                             cfg_we,
	input  wire [ces_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [ces_pkg::SCORE_W-1:0]      cfg_data,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [ces_pkg::SLOT_OUT_W-1:0]  slot,
	output logic [ces_pkg::CLASS_W-1:0]     top_class,
	output logic [ces_pkg::SCORE_W-1:0]     top_score,
	output logic [ces_pkg::COUNT_OUT_W-1:0] entry_count
);

	ces_pkg::ctrl_cmd_t cmd;
	ces_pkg::dp_stat_t  stat;

	ces_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	ces_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NUM_CLASSES   (NUM_CLASSES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.target_id   (target_id),
		.class_index (class_index),
		.verdict     (verdict),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.status      (status),
		.slot        (slot),
		.top_class   (top_class),
		.top_score   (top_score),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire
